>>> sv/stt_pkg.sv
package stt_pkg;

  localparam int unsigned SlotsDef = 512;
  localparam int unsigned IdW      = 32;
  localparam int unsigned LiveW    = 10;
  localparam int unsigned LiveMax  = (1 << LiveW) - 1;

  typedef enum logic [1:0] {
    CMD_LOGIN    = 2'd0,
    CMD_VALIDATE = 2'd1,
    CMD_REFRESH  = 2'd2,
    CMD_REVOKE   = 2'd3
  } stt_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_WR2,
    ST_RESP
  } stt_state_e;

  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] token;
    logic [IdW-1:0] user;
    logic [IdW-1:0] provider;
  } stt_slot_t;

endpackage

>>> sv/stt_req_if.sv
interface stt_req_if;
  import stt_pkg::*;

  logic           valid;
  logic           ready;
  stt_cmd_e       command;
  logic [IdW-1:0] user_code;
  logic [IdW-1:0] provider_code;
  logic [IdW-1:0] token_code;

  modport source (output valid, command, user_code, provider_code, token_code,
                  input ready);
  modport sink   (input valid, command, user_code, provider_code, token_code,
                  output ready);
endinterface

>>> sv/stt_rsp_if.sv
interface stt_rsp_if;
  import stt_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdW-1:0]   answer;
  logic             table_full;
  logic [LiveW-1:0] live_count;

  modport source (output valid, answer, table_full, live_count, input ready);
  modport sink   (input valid, answer, table_full, live_count, output ready);
endinterface

>>> sv/stt_ram.sv
module stt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/session_token_table_unit.sv
// Channel  Dir  Fields                                          Accepted when
// req_i    in   command, user_code, provider_code, token_code   valid & ready
// rsp_o    out  answer, table_full, live_count                  valid & ready
//
// Every command scans the whole slot memory, one slot per cycle through the
// single read port, then commits; a refresh that moves its entry to a lower
// slot makes a second write on the shared port to invalidate the old slot.
// After reset a clearing pass writes every slot invalid, with req_i.ready low
// throughout. A word may be accepted while the previous result still
// waits in the output register; a stalled output holds the next result back.
module session_token_table_unit #(
  parameter int unsigned SLOTS = stt_pkg::SlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_req_if.sink   req_i,
  stt_rsp_if.source rsp_o
);

  import stt_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned SW = $bits(stt_slot_t);

  stt_state_e state_q, state_d;

  logic [AW:0]      cnt_q;
  logic             chk_v_q;
  logic [AW-1:0]    chk_idx_q;
  stt_cmd_e         cmd_q;
  logic [IdW-1:0]   user_q, prov_q, tok_q;
  logic             free_hit_q, m_hit_q;
  logic [AW-1:0]    free_idx_q, m_idx_q;
  logic [IdW-1:0]   m_user_q, m_prov_q;
  logic [IdW-1:0]   ctr_q, ctr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IdW-1:0]   res_ans_q, res_ans_d;
  logic             res_full_q, res_full_d;
  logic             out_valid_q;
  logic [IdW-1:0]   out_ans_q;
  logic             out_full_q;
  logic [LiveW-1:0] out_live_q;
  logic [LiveW-1:0] live_sat;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  stt_slot_t        wr_slot, rd_slot;
  logic [SW-1:0]    ram_rdata;

  logic [IdW-1:0]   ctr_eff;
  logic [AW-1:0]    new_idx;
  logic             need_wr2;
  logic             scan_done;
  logic             out_free;
  logic             free_seen, match_seen;

  stt_ram #(
    .Width (SW),
    .Depth (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_slot    = stt_slot_t'(ram_rdata);
  assign ctr_eff    = (ctr_q == '0) ? IdW'(1) : ctr_q;
  assign new_idx    = (free_hit_q && (free_idx_q < m_idx_q)) ? free_idx_q : m_idx_q;
  assign need_wr2   = (cmd_q == CMD_REFRESH) && m_hit_q && (new_idx != m_idx_q);
  assign scan_done  = chk_v_q && (chk_idx_q == AW'(SLOTS - 1));
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign free_seen  = chk_v_q && !rd_slot.valid;
  assign match_seen = chk_v_q && rd_slot.valid && (rd_slot.token == tok_q)
                      && (tok_q != '0);
  assign live_sat   = (32'(count_q) > 32'(LiveMax)) ? LiveW'(LiveMax) : LiveW'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (cnt_q == (AW+1)'(SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_i.valid) state_d = ST_SCAN;
      ST_SCAN:  if (scan_done) state_d = ST_FIN;
      ST_FIN:   state_d = need_wr2 ? ST_WR2 : ST_RESP;
      ST_WR2:   state_d = ST_RESP;
      ST_RESP:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // memory port and commit
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AW-1:0];
    wr_slot    = '0;
    ram_re     = (state_q == ST_SCAN) && (cnt_q < (AW+1)'(SLOTS));
    ram_raddr  = cnt_q[AW-1:0];
    ctr_d      = ctr_q;
    count_d    = count_q;
    res_ans_d  = res_ans_q;
    res_full_d = res_full_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_FIN: begin
        res_ans_d  = '0;
        res_full_d = 1'b0;
        case (cmd_q)
          CMD_LOGIN: begin
            ctr_d      = ctr_eff;
            res_full_d = !free_hit_q;
            if (free_hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
              wr_slot   = '{valid: 1'b1, token: ctr_eff, user: user_q, provider: prov_q};
              ctr_d     = ctr_eff + IdW'(1);
              count_d   = count_q + CW'(1);
              res_ans_d = ctr_eff;
            end
          end
          CMD_VALIDATE: begin
            if (m_hit_q) res_ans_d = m_user_q;
          end
          CMD_REFRESH: begin
            if (m_hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = new_idx;
              wr_slot   = '{valid: 1'b1, token: ctr_eff, user: m_user_q, provider: m_prov_q};
              ctr_d     = ctr_eff + IdW'(1);
              res_ans_d = ctr_eff;
            end
          end
          CMD_REVOKE: begin
            if (m_hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = m_idx_q;
              count_d   = count_q - CW'(1);
              res_ans_d = IdW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = m_idx_q;
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      chk_v_q     <= 1'b0;
      free_hit_q  <= 1'b0;
      m_hit_q     <= 1'b0;
      ctr_q       <= IdW'(1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      count_q <= count_d;
      case (state_q)
        ST_CLEAR: cnt_q <= cnt_q + (AW+1)'(1);
        ST_IDLE: begin
          cnt_q      <= '0;
          free_hit_q <= 1'b0;
          m_hit_q    <= 1'b0;
        end
        ST_SCAN: begin
          if (ram_re) cnt_q <= cnt_q + (AW+1)'(1);
          if (free_seen && !free_hit_q) free_hit_q <= 1'b1;
          if (match_seen && !m_hit_q) m_hit_q <= 1'b1;
        end
        default: ;
      endcase
      chk_v_q <= ram_re;
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= ram_raddr;
    res_ans_q  <= res_ans_d;
    res_full_q <= res_full_d;
    if (req_i.valid && req_i.ready) begin
      cmd_q  <= req_i.command;
      user_q <= req_i.user_code;
      prov_q <= req_i.provider_code;
      tok_q  <= req_i.token_code;
    end
    if (free_seen && !free_hit_q) free_idx_q <= chk_idx_q;
    if (match_seen && !m_hit_q) begin
      m_idx_q  <= chk_idx_q;
      m_user_q <= rd_slot.user;
      m_prov_q <= rd_slot.provider;
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_ans_q  <= res_ans_q;
      out_full_q <= res_full_q;
      out_live_q <= live_sat;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.answer     = out_ans_q;
  assign rsp_o.table_full = out_full_q;
  assign rsp_o.live_count = out_live_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(SLOTS))
    else $error("live count above slot count");

  a_scan_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !chk_v_q && !ram_re)
    else $error("commit while scan reads in flight");

  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");

  a_id_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && ram_we && wr_slot.valid |-> wr_slot.token != '0)
    else $error("zero token id allocated");

endmodule
